>>> src/ssfe_pkg.sv
// ----------------------------------------------------------------------------
// ssfe_pkg
// Shared types, constants and encoding functions of the seven-segment frame
// encoder: segment table, uuencode mapping, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssfe_pkg;

  localparam int MAX_CHARS_DEF = 4;
  localparam int NUM_CHAR_PORTS = 4;
  localparam int FRAME_HDR = 5;        // length, position, command, blink, checksum

  localparam logic [7:0] STX_BYTE  = 8'h01;
  localparam logic [7:0] ETX_BYTE  = 8'h03;
  localparam logic [7:0] UU_ZERO   = 8'h60;
  localparam logic [7:0] UU_BIAS   = 8'h20;
  localparam logic [7:0] CHAR_BASE = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_END
  } ssfe_state_t;

  typedef struct packed {
    logic load;
    logic emit_start;
    logic emit_data;
    logic emit_end;
  } ssfe_cmd_t;

  typedef struct packed {
    logic out_free;
    logic data_done;
  } ssfe_sts_t;

  // Seven-segment pattern for a table index; indexes past 'Z' are blank.
  function automatic logic [7:0] seg_pattern(input logic [5:0] idx);
    logic [7:0] pat;
    unique case (idx)
      6'd13:   pat = 8'h40;
      6'd16:   pat = 8'h3F;
      6'd17:   pat = 8'h06;
      6'd18:   pat = 8'h5B;
      6'd19:   pat = 8'h4F;
      6'd20:   pat = 8'h66;
      6'd21:   pat = 8'h6D;
      6'd22:   pat = 8'h7D;
      6'd23:   pat = 8'h07;
      6'd24:   pat = 8'h7F;
      6'd25:   pat = 8'h6F;
      6'd33:   pat = 8'h77;
      6'd34:   pat = 8'h7C;
      6'd35:   pat = 8'h39;
      6'd36:   pat = 8'h5E;
      6'd37:   pat = 8'h79;
      6'd38:   pat = 8'h71;
      6'd39:   pat = 8'h6F;
      6'd40:   pat = 8'h74;
      6'd41:   pat = 8'h30;
      6'd42:   pat = 8'h0E;
      6'd44:   pat = 8'h38;
      6'd46:   pat = 8'h54;
      6'd47:   pat = 8'h5C;
      6'd48:   pat = 8'h73;
      6'd49:   pat = 8'h67;
      6'd50:   pat = 8'h50;
      6'd51:   pat = 8'h6D;
      6'd53:   pat = 8'h3E;
      6'd54:   pat = 8'h1C;
      6'd56:   pat = 8'h76;
      6'd57:   pat = 8'h66;
      6'd58:   pat = 8'h5B;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // Segment byte: pattern shifted left, dot in bit 0.
  function automatic logic [7:0] seg_byte(input logic [7:0] ch, input logic dot);
    logic [7:0] rel;
    logic [7:0] pat;
    rel = ch - CHAR_BASE;
    pat = seg_pattern(rel[5:0]);
    return {pat[6:0], dot};
  endfunction

  // Printable form of one 6-bit value; zero goes out as a backquote.
  function automatic logic [7:0] uu_char(input logic [5:0] v);
    logic [7:0] c;
    if (v == 6'd0) begin
      c = UU_ZERO;
    end else begin
      c = {2'b00, v} + UU_BIAS;
    end
    return c;
  endfunction

endpackage

>>> src/ssfe_ctrl.sv
// ----------------------------------------------------------------------------
// ssfe_ctrl
// Sequencer: takes a message, then walks start byte, encoded groups and end
// byte, issuing one emit command per free output slot.
// ----------------------------------------------------------------------------
module ssfe_ctrl
  import ssfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ssfe_sts_t sts,
  output ssfe_cmd_t cmd
);

  ssfe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (sts.out_free) begin
          cmd.emit_start = 1'b1;
          state_nxt      = ST_DATA;
        end
      end
      ST_DATA: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          if (sts.data_done) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/ssfe_dp.sv
// ----------------------------------------------------------------------------
// ssfe_dp
// Datapath: position register, frame builder with checksum, frame shift line
// read three bytes at a time, sextet select and the output register.
// ----------------------------------------------------------------------------
module ssfe_dp
  import ssfe_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ssfe_cmd_t  cmd,
  output ssfe_sts_t  sts,
  input  logic       cfg_we,
  input  logic [7:0] cfg_position_byte,
  input  logic [7:0] in_char_0,
  input  logic [7:0] in_char_1,
  input  logic [7:0] in_char_2,
  input  logic [7:0] in_char_3,
  input  logic [2:0] in_char_count,
  input  logic [7:0] in_dot_mask,
  input  logic [7:0] in_command_byte,
  input  logic [7:0] in_blink_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  localparam int FRAME_LEN_MAX = MAX_CHARS + FRAME_HDR;
  localparam int NUM_GRP       = (FRAME_LEN_MAX + 2) / 3;
  localparam int FRAME_DEPTH   = 3 * NUM_GRP;
  localparam int GW            = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

  logic [7:0]    pos_r;
  logic [7:0]    frame_r   [FRAME_DEPTH];
  logic [7:0]    frame_nxt [FRAME_DEPTH];
  logic [GW-1:0] grp_r, grp_last_r;
  logic [1:0]    sext_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_valid_r;

  logic [7:0]    chars [NUM_CHAR_PORTS];
  logic [7:0]    seg_w [MAX_CHARS];
  logic [2:0]    cnt;
  logic [3:0]    len;
  logic [7:0]    csum;
  logic [23:0]   grp_word;
  logic [5:0]    sextet;

  assign chars[0] = in_char_0;
  assign chars[1] = in_char_1;
  assign chars[2] = in_char_2;
  assign chars[3] = in_char_3;

  // Clamp the count to the configured character capacity.
  assign cnt = (in_char_count > 3'(MAX_CHARS)) ? 3'(MAX_CHARS) : in_char_count;
  assign len = {1'b0, cnt} + 4'(FRAME_HDR);

  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      seg_w[i] = seg_byte(chars[i], in_dot_mask[i]);
    end
  end

  always_comb begin
    csum = {4'd0, len} ^ pos_r ^ in_command_byte ^ in_blink_byte;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (cnt > 3'(i)) begin
        csum = csum ^ seg_w[i];
      end
    end
  end

  // Raw frame, zero past the checksum so the last group pads itself.
  for (genvar p = 0; p < FRAME_DEPTH; p++) begin : g_frame
    if (p == 0) begin : g_len
      assign frame_nxt[p] = {4'd0, len};
    end else if (p == 1) begin : g_pos
      assign frame_nxt[p] = pos_r;
    end else if (p == 2) begin : g_cmd
      assign frame_nxt[p] = in_command_byte;
    end else if (p == 3) begin : g_blink
      assign frame_nxt[p] = in_blink_byte;
    end else if (p - 4 < MAX_CHARS) begin : g_seg
      assign frame_nxt[p] = (len == 4'(p + 1)) ? csum :
                            (cnt > 3'(p - 4)) ? seg_w[p - 4] : 8'h00;
    end else begin : g_tail
      assign frame_nxt[p] = (len == 4'(p + 1)) ? csum : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 8'h00;
    end else if (cfg_we) begin
      pos_r <= cfg_position_byte;
    end
  end

  // Load the frame, then shift one group out after its fourth character.
  always_ff @(posedge clk) begin
    for (int p = 0; p < FRAME_DEPTH; p++) begin
      if (cmd.load) begin
        frame_r[p] <= frame_nxt[p];
      end else if (cmd.emit_data && sext_r == 2'd3) begin
        frame_r[p] <= (p + 3 < FRAME_DEPTH) ? frame_r[(p + 3) % FRAME_DEPTH] : 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r      <= '0;
      grp_last_r <= '0;
      sext_r     <= 2'd0;
    end else if (cmd.load) begin
      grp_r      <= '0;
      grp_last_r <= (len >= 4'd7) ? GW'(2) : GW'(1);
      sext_r     <= 2'd0;
    end else if (cmd.emit_data) begin
      sext_r <= sext_r + 2'd1;
      if (sext_r == 2'd3) begin
        grp_r <= grp_r + GW'(1);
      end
    end
  end

  assign grp_word = {frame_r[0], frame_r[1], frame_r[2]};

  always_comb begin
    unique case (sext_r)
      2'd0:    sextet = grp_word[23:18];
      2'd1:    sextet = grp_word[17:12];
      2'd2:    sextet = grp_word[11:6];
      default: sextet = grp_word[5:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_start || cmd.emit_data || cmd.emit_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      out_byte_r <= STX_BYTE;
      out_last_r <= 1'b0;
    end else if (cmd.emit_data) begin
      out_byte_r <= uu_char(sextet);
      out_last_r <= 1'b0;
    end else if (cmd.emit_end) begin
      out_byte_r <= ETX_BYTE;
      out_last_r <= 1'b1;
    end
  end

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.data_done = (sext_r == 2'd3) && (grp_r == grp_last_r);

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

>>> src/seven_segment_frame_encoder.sv
// ----------------------------------------------------------------------------
// seven_segment_frame_encoder
// Message in, uuencoded seven-segment display frame out, one byte per beat.
// ----------------------------------------------------------------------------
// Each input beat carries up to four ASCII characters, their count, a dot
// mask and two command bytes. The block builds the display frame (length,
// position, command, blink, one segment byte per character, XOR checksum),
// uuencodes it three bytes to four printable characters with zero padding,
// and sends it wrapped in 0x01 ... 0x03, with out_last_byte marking the 0x03.
// That is 10 output beats for messages of zero or one character and 14 for
// two to four. One message is worked on at a time: in_stall stays high from
// the accepting edge until the closing 0x03 has been loaded into the output
// register; with no output stall the output register sends one byte per
// cycle. The 0x03 may still sit in the output register while the next
// message is accepted.
// position_byte is written through cfg_valid/cfg_ready (cfg_ready is always
// high); write it only while no message is in flight. Characters past the
// count are ignored. A character picks its pattern by its offset from space
// taken modulo 64, so some codes outside space..Z wrap onto real patterns;
// offsets past 'Z' show blank.
// ----------------------------------------------------------------------------
module seven_segment_frame_encoder
  import ssfe_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_position_byte,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_0,
  input  logic [7:0] in_char_1,
  input  logic [7:0] in_char_2,
  input  logic [7:0] in_char_3,
  input  logic [2:0] in_char_count,
  input  logic [7:0] in_dot_mask,
  input  logic [7:0] in_command_byte,
  input  logic [7:0] in_blink_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  ssfe_cmd_t cmd;
  ssfe_sts_t sts;

  // The position register takes every write, so never hold off the writer.
  assign cfg_ready = 1'b1;

  // Sequence start byte, data groups and end byte.
  ssfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Build, encode and drive the frame bytes.
  ssfe_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_position_byte (cfg_position_byte),
    .in_char_0         (in_char_0),
    .in_char_1         (in_char_1),
    .in_char_2         (in_char_2),
    .in_char_3         (in_char_3),
    .in_char_count     (in_char_count),
    .in_dot_mask       (in_dot_mask),
    .in_command_byte   (in_command_byte),
    .in_blink_byte     (in_blink_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte)
  );

endmodule

>>> src/ssfe_checker.sv
// ----------------------------------------------------------------------------
// ssfe_checker
// Port-level checks of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ssfe_checker
  import ssfe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_byte
);

  // A stalled output beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_byte))
    else $error("output beat changed while stalled");

  // After a message is taken, the input is stalled.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a message");

  // The closing beat is always the end byte.
  a_last_is_etx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_byte == ETX_BYTE)
    else $error("last beat is not the end byte");

  // No other beat carries the end byte.
  a_etx_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |-> out_byte != ETX_BYTE)
    else $error("end byte seen before the last beat");

endmodule

bind seven_segment_frame_encoder ssfe_checker u_ssfe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_last_byte (out_last_byte)
);
